// ===== rtl/range_two_smallest_tree_macros.svh =====
// Assertion macros shared by the range_two_smallest_tree RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef RANGE_TWO_SMALLEST_TREE_MACROS_SVH
`define RANGE_TWO_SMALLEST_TREE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define RTST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RTST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rtst_pkg.sv =====
// Package for the range two-smallest segment tree: payload structs, node pair
// type, merge function, controller states and controller/datapath signal groups.
// No dependencies.
`default_nettype none

package rtst_pkg;

  localparam int unsigned LeavesDefault = 1024;
  localparam logic signed [31:0] IntMax = 32'sh7fff_ffff;

  typedef enum logic {
    KIND_UPDATE = 1'b0,
    KIND_QUERY  = 1'b1
  } kind_e;

  // Input transaction
  typedef struct packed {
    kind_e              kind;
    logic [9:0]         slot_index;
    logic signed [31:0] new_value;
    logic [10:0]        range_low;
    logic [10:0]        range_high;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic signed [31:0] smallest;
    logic signed [31:0] second_smallest;
  } result_t;

  // One tree node: least and second least of its range
  typedef struct packed {
    logic signed [31:0] least;
    logic signed [31:0] second;
  } pair_t;

  localparam pair_t EmptyPair = '{least: IntMax, second: IntMax};

  // Two smallest of the union of two ranges, repeats counted
  function automatic pair_t merge_pair(pair_t a, pair_t b);
    pair_t r;
    if (a.least < b.least) begin
      r.least  = a.least;
      r.second = (a.second < b.least) ? a.second : b.least;
    end else begin
      r.least  = b.least;
      r.second = (b.second < a.least) ? b.second : a.least;
    end
    return r;
  endfunction

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_LEAF,
    ST_UPD_LEVEL,
    ST_Q_RUN,
    ST_Q_DRAIN,
    ST_Q_OUT
  } state_e;

  // Controller commands to the datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic upd_leaf;
    logic upd_level;
    logic q_run;
  } ctrl_t;

  // Datapath status to the controller
  typedef struct packed {
    logic clr_last;
    logic slot_ok;
    logic at_top;
    logic lo_lt_hi;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/rtst_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module rtst_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 2048
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr1_i,
  output logic      [WIDTH-1:0]         rdata0_o,
  output logic      [WIDTH-1:0]         rdata1_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports (old data on a same-address write)
  always_ff @(posedge clk_i) begin
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end

endmodule

`default_nettype wire

// ===== rtl/rtst_ctrl.sv =====
// Controller for the range two-smallest segment tree: clear pass, update walk
// and query loop sequencing. Depends on rtst_pkg.
`default_nettype none

module rtst_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  input  wire rtst_pkg::kind_e kind_i,
  input  wire rtst_pkg::stat_t stat_i,
  output rtst_pkg::ctrl_t      ctrl_o,
  output logic                 busy_o,
  output logic                 result_valid_o
);
  import rtst_pkg::*;

  state_e state_q, state_d;

  // State register; reset starts the clear pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d        = state_q;
    ctrl_o         = '0;
    result_valid_o = 1'b0;
    busy_o         = (state_q != ST_IDLE);
    case (state_q)
      ST_CLEAR: begin
        ctrl_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          ctrl_o.load = 1'b1;
          if (kind_i == KIND_QUERY) begin
            state_d = ST_Q_RUN;
          end else if (stat_i.slot_ok) begin
            state_d = ST_UPD_LEAF;
          end
        end
      end
      ST_UPD_LEAF: begin
        ctrl_o.upd_leaf = 1'b1;
        state_d         = ST_UPD_LEVEL;
      end
      ST_UPD_LEVEL: begin
        ctrl_o.upd_level = 1'b1;
        if (stat_i.at_top) begin
          state_d = ST_IDLE;
        end
      end
      ST_Q_RUN: begin
        ctrl_o.q_run = 1'b1;
        if (!stat_i.lo_lt_hi) begin
          state_d = ST_Q_DRAIN;
        end
      end
      ST_Q_DRAIN: begin
        state_d = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/rtst_dp.sv =====
// Datapath for the range two-smallest segment tree: node store, update walk
// registers, query bounds, merge pipeline and accumulator.
// Depends on rtst_pkg, rtst_ram and range_two_smallest_tree_macros.svh.
`default_nettype none
`include "range_two_smallest_tree_macros.svh"

module rtst_dp #(
  parameter int unsigned LEAVES = rtst_pkg::LeavesDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rtst_pkg::cmd_t  cmd_i,
  input  wire rtst_pkg::ctrl_t ctrl_i,
  output rtst_pkg::stat_t      stat_o,
  output rtst_pkg::result_t    result_o
);
  import rtst_pkg::*;

  localparam int unsigned Span  = 1 << $clog2(LEAVES);
  localparam int unsigned Depth = 2 * Span;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned QW    = AddrW + 1;

  // Clear pass counter and pipeline flags (control)
  logic [AddrW-1:0] clr_cnt_q;
  logic             s1_lo_q, s1_hi_q, s2_v_q;

  // Payload registers
  logic [AddrW-1:0] pos_q;
  pair_t            cur_q;
  logic [QW-1:0]    lo_q, hi_q;
  pair_t            m_q, acc_q;

  // Memory ports
  logic             we;
  logic [AddrW-1:0] waddr, raddr0, raddr1;
  pair_t            wdata;
  logic [63:0]      rdata0, rdata1;

  logic [AddrW-1:0] par;
  pair_t            sib, merged, m_d;
  logic [QW-1:0]    hi_m1, lo_start, hi_start;
  logic [31:0]      lo_ext, hi_ext;
  logic             issue;

  rtst_ram #(
    .WIDTH($bits(pair_t)),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr0_i(raddr0),
    .raddr1_i(raddr1),
    .rdata0_o(rdata0),
    .rdata1_o(rdata1)
  );

  // Update walk: merge the new child with its sibling, keeping left/right order
  assign par    = pos_q >> 1;
  assign sib    = pair_t'(rdata0);
  assign merged = pos_q[0] ? merge_pair(sib, cur_q) : merge_pair(cur_q, sib);

  // Query bounds clamped to the leaf count and moved to leaf level
  assign lo_ext   = 32'(cmd_i.range_low);
  assign hi_ext   = 32'(cmd_i.range_high);
  assign lo_start = QW'((lo_ext > LEAVES) ? LEAVES : lo_ext) + QW'(Span);
  assign hi_start = QW'((hi_ext > LEAVES) ? LEAVES : hi_ext) + QW'(Span);
  assign hi_m1    = hi_q - QW'(1);
  assign issue    = ctrl_i.q_run & (lo_q < hi_q);

  // Status
  assign stat_o.clr_last = (clr_cnt_q == '1);
  assign stat_o.slot_ok  = (32'(cmd_i.slot_index) < LEAVES);
  assign stat_o.at_top   = (par == AddrW'(1));
  assign stat_o.lo_lt_hi = (lo_q < hi_q);

  // Memory port selection
  always_comb begin
    we     = 1'b0;
    waddr  = pos_q;
    wdata  = cur_q;
    raddr0 = pos_q ^ AddrW'(1);
    raddr1 = hi_m1[AddrW-1:0];
    if (ctrl_i.clear) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = EmptyPair;
    end else if (ctrl_i.upd_leaf) begin
      we = 1'b1;
    end else if (ctrl_i.upd_level) begin
      we     = 1'b1;
      waddr  = par;
      wdata  = merged;
      raddr0 = par ^ AddrW'(1);
    end else if (ctrl_i.q_run) begin
      raddr0 = lo_q[AddrW-1:0];
    end
  end

  // First merge stage: the up-to-two nodes picked in one loop step
  assign m_d = merge_pair(s1_lo_q ? pair_t'(rdata0) : EmptyPair,
                          s1_hi_q ? pair_t'(rdata1) : EmptyPair);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      s1_lo_q   <= 1'b0;
      s1_hi_q   <= 1'b0;
      s2_v_q    <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AddrW'(1);
      end
      s1_lo_q <= issue & lo_q[0];
      s1_hi_q <= issue & hi_q[0];
      s2_v_q  <= s1_lo_q | s1_hi_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    if (ctrl_i.load) begin
      pos_q        <= AddrW'(cmd_i.slot_index) + AddrW'(Span);
      cur_q.least  <= cmd_i.new_value;
      cur_q.second <= IntMax;
      lo_q         <= lo_start;
      hi_q         <= hi_start;
      acc_q        <= EmptyPair;
    end else begin
      if (ctrl_i.upd_level) begin
        pos_q <= par;
        cur_q <= merged;
      end
      if (issue) begin
        lo_q <= (lo_q + QW'(lo_q[0])) >> 1;
        hi_q <= hi_q >> 1;
      end
      if (s2_v_q) begin
        acc_q <= merge_pair(acc_q, m_q);
      end
    end
  end

  assign result_o.smallest        = acc_q.least;
  assign result_o.second_smallest = acc_q.second;

  `RTST_ASSERT_NOW(a_pair_order, clk_i, rst_ni, s2_v_q, m_q.least <= m_q.second,
                   "merged node pair out of order")
  `RTST_ASSERT_NOW(a_walk_root, clk_i, rst_ni, ctrl_i.upd_level, par != '0,
                   "update walk went past the root")

endmodule

`default_nettype wire

// ===== rtl/range_two_smallest_tree.sv =====
// Range two-smallest segment tree: an update writes one leaf and recombines
// its ancestors level by level, from the leaf's parent up to the root; an
// update with slot_index at or past LEAVES is dropped at once. A query walks
// its bounds up the tree one level per cycle, reading at most two nodes per
// step from the two read ports of the node store. S is LEAVES rounded up to a
// power of two, and the walk takes at most log2(S)+1 steps; after the walk,
// busy stays high while the controller sees the bounds meet, drains the merge
// pipeline and gives the strobe. After reset the block clears all 2*S nodes,
// one per cycle, with busy held high. busy stays high until the current
// transaction is finished; result_valid_o is high for exactly one cycle per
// query and the receiver cannot hold it off.
// Depends on rtst_pkg, rtst_ctrl, rtst_dp and range_two_smallest_tree_macros.svh.
`default_nettype none
`include "range_two_smallest_tree_macros.svh"

module range_two_smallest_tree #(
  parameter int unsigned LEAVES = rtst_pkg::LeavesDefault
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire rtst_pkg::cmd_t    cmd_i,
  output logic                   busy,
  output logic                   result_valid_o,
  output rtst_pkg::result_t      result_o
);
  import rtst_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  rtst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .kind_i        (cmd_i.kind),
    .stat_i        (stat),
    .ctrl_o        (ctrl),
    .busy_o        (busy),
    .result_valid_o(result_valid_o)
  );

  rtst_dp #(
    .LEAVES(LEAVES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .ctrl_i  (ctrl),
    .stat_o  (stat),
    .result_o(result_o)
  );

  `RTST_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, result_valid_o, !result_valid_o,
                    "result strobe longer than one cycle")
  `RTST_ASSERT_NOW(a_strobe_busy, clk_i, rst_ni, result_valid_o, busy,
                   "result strobe while a new transaction could be taken")
  `RTST_ASSERT_NEXT(a_update_silent, clk_i, rst_ni,
                    start && !busy && cmd_i.kind == KIND_UPDATE, !result_valid_o,
                    "update produced a result")

endmodule

`default_nettype wire
